### hdl/pmpt_pkg.sv
// ----------------------------------------------------------------------------
// pmpt_pkg
// shared types and constants for the mouse packet tracker
// ----------------------------------------------------------------------------
`default_nettype none

package pmpt_pkg;

    // position register width
    localparam int POS_BITS_DEFAULT = 10;

    // fixed field widths
    localparam int BYTE_W   = 8;
    localparam int LIMIT_W  = 10;
    localparam int CURSOR_W = 10;
    localparam int BTN_W    = 3;

    // header byte bit positions
    localparam int HDR_LEFT_BIT   = 0;
    localparam int HDR_RIGHT_BIT  = 1;
    localparam int HDR_MIDDLE_BIT = 2;
    localparam int HDR_SYNC_BIT   = 3;

    // reset values
    localparam logic [LIMIT_W-1:0] X_LIMIT_RESET = 10'd319;
    localparam logic [LIMIT_W-1:0] Y_LIMIT_RESET = 10'd199;
    localparam int POS_X_RESET = 160;
    localparam int POS_Y_RESET = 100;

    // register map
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam logic REG_X_LIMIT = 1'b0;
    localparam logic REG_Y_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        SLOT_HEADER = 2'd0,
        SLOT_X      = 2'd1,
        SLOT_Y      = 2'd2
    } t_slot;

endpackage

`default_nettype wire

### hdl/ps2_mouse_packet_tracker.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker
// three-byte mouse stream decoder with clamped cursor position tracking
// ----------------------------------------------------------------------------
// Takes one raw mouse byte per beat and accepts a new byte every clock cycle
// while o_stall is low. A byte is registered on input: a header byte sets the
// buttons, an X byte is kept, and a Y byte drives a small add and clamp
// against the configured limit into the output register. A header byte
// without bit 3 set is dropped to regain packet alignment. The output
// register holds a result while stalled; the input side stalls only when a
// packet completes while that register is still occupied and held off.
`default_nettype none

module ps2_mouse_packet_tracker #(
    parameter int POS_BITS = pmpt_pkg::POS_BITS_DEFAULT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,

    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pmpt_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [pmpt_pkg::PDATA_W-1:0]   pwdata,
    output logic      [pmpt_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready,

    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [pmpt_pkg::BYTE_W-1:0]    i_data_byte,

    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic      [pmpt_pkg::CURSOR_W-1:0]  o_cursor_x,
    output logic      [pmpt_pkg::CURSOR_W-1:0]  o_cursor_y,
    output logic                                o_left_button,
    output logic                                o_right_button,
    output logic                                o_middle_button
);

    import pmpt_pkg::*;

    // sum width: position plus signed delta with room for sign and carry
    localparam int CW = POS_BITS + 2;
    localparam logic [CW-1:0] POS_MAX_C = CW'((1 << POS_BITS) - 1);

    // configuration
    logic [LIMIT_W-1:0]  r_x_limit;
    logic [LIMIT_W-1:0]  r_y_limit;

    // input register
    logic                r_in_valid;
    logic [BYTE_W-1:0]   r_in_byte;

    // packet state
    t_slot               r_slot, n_slot;
    logic [BTN_W-1:0]    r_buttons, n_buttons;
    logic [BYTE_W-1:0]   r_dx, n_dx;
    logic [POS_BITS-1:0] r_pos_x, n_pos_x;
    logic [POS_BITS-1:0] r_pos_y, n_pos_y;

    // output register
    logic                r_out_valid;
    logic [CURSOR_W-1:0] r_out_x;
    logic [CURSOR_W-1:0] r_out_y;
    logic [BTN_W-1:0]    r_out_btn;

    logic                w_result;
    logic                w_proceed;
    logic                w_in_take;
    logic                w_cfg_wr;
    logic [CW-1:0]       w_sum_x;
    logic [CW-1:0]       w_sum_y;
    logic [CW-1:0]       w_lim_x;
    logic [CW-1:0]       w_lim_y;
    logic [POS_BITS-1:0] w_clamp_x;
    logic [POS_BITS-1:0] w_clamp_y;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_limit <= X_LIMIT_RESET;
            r_y_limit <= Y_LIMIT_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_X_LIMIT: r_x_limit <= pwdata[LIMIT_W-1:0];
                REG_Y_LIMIT: r_y_limit <= pwdata[LIMIT_W-1:0];
                default:     r_x_limit <= r_x_limit;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_X_LIMIT: prdata = PDATA_W'(r_x_limit);
            REG_Y_LIMIT: prdata = PDATA_W'(r_y_limit);
            default:     prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign w_result  = (r_slot == SLOT_Y);
    // only a completing packet can be held up by a full output register
    assign w_proceed = !(w_result && r_out_valid && i_stall);
    assign o_stall   = r_in_valid && !w_proceed;
    assign w_in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_proceed) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_data_byte;
        end
    end

    // ---------------- position arithmetic ----------------
    assign w_sum_x = CW'(r_pos_x) + {{(CW-BYTE_W){r_dx[BYTE_W-1]}}, r_dx};
    assign w_sum_y = CW'(r_pos_y) - {{(CW-BYTE_W){r_in_byte[BYTE_W-1]}}, r_in_byte};

    // a limit beyond the position range saturates to the largest position
    assign w_lim_x = (CW'(r_x_limit) > POS_MAX_C) ? POS_MAX_C : CW'(r_x_limit);
    assign w_lim_y = (CW'(r_y_limit) > POS_MAX_C) ? POS_MAX_C : CW'(r_y_limit);

    always_comb begin
        if (w_sum_x[CW-1]) begin
            w_clamp_x = '0;
        end else if (w_sum_x > w_lim_x) begin
            w_clamp_x = w_lim_x[POS_BITS-1:0];
        end else begin
            w_clamp_x = w_sum_x[POS_BITS-1:0];
        end
    end

    always_comb begin
        if (w_sum_y[CW-1]) begin
            w_clamp_y = '0;
        end else if (w_sum_y > w_lim_y) begin
            w_clamp_y = w_lim_y[POS_BITS-1:0];
        end else begin
            w_clamp_y = w_sum_y[POS_BITS-1:0];
        end
    end

    // ---------------- packet sequencing ----------------
    always_comb begin
        n_slot    = r_slot;
        n_buttons = r_buttons;
        n_dx      = r_dx;
        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        case (r_slot)
            SLOT_X: begin
                n_dx   = r_in_byte;
                n_slot = SLOT_Y;
            end
            SLOT_Y: begin
                n_pos_x = w_clamp_x;
                n_pos_y = w_clamp_y;
                n_slot  = SLOT_HEADER;
            end
            default: begin
                // bytes without the sync bit are dropped here
                if (r_in_byte[HDR_SYNC_BIT]) begin
                    n_buttons = {r_in_byte[HDR_MIDDLE_BIT], r_in_byte[HDR_RIGHT_BIT],
                                 r_in_byte[HDR_LEFT_BIT]};
                    n_slot    = SLOT_X;
                end else begin
                    n_slot    = SLOT_HEADER;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= SLOT_HEADER;
            r_buttons <= '0;
            r_dx      <= '0;
            r_pos_x   <= POS_BITS'(POS_X_RESET);
            r_pos_y   <= POS_BITS'(POS_Y_RESET);
        end else if (r_in_valid && w_proceed) begin
            r_slot    <= n_slot;
            r_buttons <= n_buttons;
            r_dx      <= n_dx;
            r_pos_x   <= n_pos_x;
            r_pos_y   <= n_pos_y;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_in_valid && w_proceed && w_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && w_proceed && w_result) begin
            r_out_x   <= CURSOR_W'(w_clamp_x);
            r_out_y   <= CURSOR_W'(w_clamp_y);
            r_out_btn <= r_buttons;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_cursor_x      = r_out_x;
    assign o_cursor_y      = r_out_y;
    assign o_left_button   = r_out_btn[0];
    assign o_right_button  = r_out_btn[1];
    assign o_middle_button = r_out_btn[2];

endmodule

`default_nettype wire
